FILE: hdl/uld_pkg.sv
// ----------------------------------------------------------------------------
// uld_pkg
// shared types and constants for the lenient utf-8 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package uld_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxOut  = 4;
  localparam int unsigned PendD   = 3;

  // expected sequence lengths
  localparam logic [2:0] LenNone  = 3'd0;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           raw_fallback;
    logic           last_in_run;
    logic           text_done;
  } result_t;

  // results produced by one accepted byte, first result in item[0]
  typedef struct packed {
    logic                     load;
    logic [2:0]               n;
    result_t [MaxOut-1:0]     item;
  } batch_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = LenNone;
    if ((b & 8'hE0) == 8'hC0) begin
      len = LenTwo;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = LenThree;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = LenFour;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_lenient_decoder.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder
// streaming utf-8 decoder; broken or unfinished sequences pass through raw
// ----------------------------------------------------------------------------
// the first result of a byte is registered and appears in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one result and m_tready
//   stays high; a byte yielding n results (up to 4) holds the input until the one-batch
//   result register, draining one result per cycle while m_tready is high, reaches its last
// reset: synchronous rst clears the sequence state and empties the results
`default_nettype none

module utf8_lenient_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]       m_tuser,   // [0] raw_fallback, [1] last_in_run
  output logic             m_tlast    // text_done
);
  import uld_pkg::*;

  batch_t  batch;
  result_t head;
  logic    take;
  logic    accept;

  assign s_tready = take;
  assign accept   = s_tvalid && take;

  uld_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (s_tdata),
    .end_of_text (s_tlast),
    .batch       (batch)
  );

  uld_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .batch      (batch),
    .take       (take),
    .head       (head),
    .head_valid (m_tvalid),
    .head_ready (m_tready)
  );

  assign m_tdata = {3'd0, head.code_point};
  assign m_tuser = {head.last_in_run, head.raw_fallback};
  assign m_tlast = head.text_done;

endmodule

`default_nettype wire

FILE: hdl/uld_decode.sv
// ----------------------------------------------------------------------------
// uld_decode
// sequence state and per-byte decode: builds the result batch for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module uld_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_text,
  output uld_pkg::batch_t    batch
);
  import uld_pkg::*;

  logic [7:0] pend [PendD];
  logic [1:0] pcount;
  logic [2:0] slen;

  logic [1:0] pcount_next;
  logic [2:0] slen_next;
  logic       wr_pend;
  logic [1:0] wr_idx;

  logic           idle;
  logic           is_cont;
  logic           completes;
  logic           flush;
  logic           has_tail;
  logic [CpW-1:0] tail_cp;
  logic           tail_raw;
  logic [2:0]     base;
  logic [2:0]     cnt;
  logic [2:0]     new_len;
  logic [CpW-1:0] dec_cp;

  always_comb begin
    idle      = (pcount == 2'd0) || (slen < LenTwo) || (slen > LenFour);
    is_cont   = (text_byte[7:6] == 2'b10);
    completes = ({1'b0, pcount} + 3'd1) == slen;
    new_len   = lead_length(text_byte);

    unique case (slen)
      LenTwo:   dec_cp = {10'd0, pend[0][4:0], text_byte[5:0]};
      LenThree: dec_cp = {5'd0, pend[0][3:0], pend[1][5:0], text_byte[5:0]};
      default:  dec_cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], text_byte[5:0]};
    endcase

    flush       = 1'b0;
    has_tail    = 1'b0;
    tail_cp     = {13'd0, text_byte};
    tail_raw    = 1'b1;
    pcount_next = pcount;
    slen_next   = slen;
    wr_pend     = 1'b0;
    wr_idx      = 2'd0;

    // start_byte behavior is shared by idle and breaking-byte paths
    priority if (!idle && is_cont && completes) begin
      has_tail    = 1'b1;
      tail_cp     = dec_cp;
      tail_raw    = 1'b0;
      pcount_next = 2'd0;
      slen_next   = LenNone;
    end else if (!idle && is_cont && end_of_text) begin
      flush       = 1'b1;
      has_tail    = 1'b1;
      pcount_next = 2'd0;
      slen_next   = LenNone;
    end else if (!idle && is_cont) begin
      wr_pend     = 1'b1;
      wr_idx      = pcount;
      pcount_next = pcount + 2'd1;
    end else begin
      flush       = !idle;
      pcount_next = 2'd0;
      slen_next   = LenNone;
      if (!text_byte[7]) begin
        has_tail = 1'b1;
        tail_raw = 1'b0;
      end else if (new_len == LenNone || end_of_text) begin
        has_tail = 1'b1;
      end else begin
        wr_pend     = 1'b1;
        wr_idx      = 2'd0;
        pcount_next = 2'd1;
        slen_next   = new_len;
      end
    end

    base = flush ? {1'b0, pcount} : 3'd0;
    cnt  = base + {2'b0, has_tail};

    batch.load = accept;
    batch.n    = cnt;
    for (int i = 0; i < MaxOut; i++) begin
      batch.item[i].code_point   = tail_cp;
      batch.item[i].raw_fallback = tail_raw;
      if (flush && (3'(i) < base)) begin
        batch.item[i].code_point   = {13'd0, pend[i % PendD]};
        batch.item[i].raw_fallback = 1'b1;
      end
      batch.item[i].last_in_run = (3'(i) + 3'd1) == cnt;
      batch.item[i].text_done   = ((3'(i) + 3'd1) == cnt) && end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= 2'd0;
      slen   <= LenNone;
    end else if (accept) begin
      pcount <= pcount_next;
      slen   <= slen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_pend) begin
      pend[wr_idx] <= text_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/uld_outq.sv
// ----------------------------------------------------------------------------
// uld_outq
// result register: holds a byte's batch; while head_ready, one out per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module uld_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire uld_pkg::batch_t batch,
  output logic                 take,
  output uld_pkg::result_t     head,
  output logic                 head_valid,
  input  wire logic            head_ready
);
  import uld_pkg::*;

  result_t    items [MaxOut];
  logic [2:0] qn;
  logic       pop;

  assign head_valid = (qn != 3'd0);
  assign head       = items[0];
  assign pop        = head_valid && head_ready;
  // a new batch may enter as the last queued result leaves
  assign take       = (qn == 3'd0) || ((qn == 3'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      qn <= 3'd0;
    end else if (batch.load) begin
      qn <= batch.n;
    end else if (pop) begin
      qn <= qn - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (batch.load) begin
      for (int i = 0; i < MaxOut; i++) begin
        items[i] <= batch.item[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MaxOut - 1; i++) begin
        items[i] <= items[i + 1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_utf8_lenient_decoder.sv
// ----------------------------------------------------------------------------
// tb_utf8_lenient_decoder
// Drives byte streams into the lenient utf-8 decoder and checks every
// result against a behavioral decoder kept in step with it, or against fixed
// expected results for the typed script rows. A short scripted run covers the
// byte classes and the fallback cases. Random text follows, mostly well-formed
// characters with some broken ones and noise, under three stall patterns, the last with no stalls.
// ----------------------------------------------------------------------------

module tb_utf8_lenient_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import uld_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ScriptLen  = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  utf8_lenient_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] text_byte
    .s_tlast  (s_tlast),   // end_of_text
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [20:0] code_point, [23:21] zero
    .m_tuser  (m_tuser),   // [0] raw_fallback, [1] last_in_run
    .m_tlast  (m_tlast)    // text_done
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral decoder
  // ---------------------------------------------------------------------------
  logic [7:0] held_bytes [PendD];
  logic [1:0] held_cnt = 2'd0;
  logic [2:0] want_len = LenNone;

  result_t    step_points [$];   // code points caused by the current request
  result_t    awaited     [$];   // code points not yet seen at the output

  int         errors = 0;
  int         sent_items = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         take_idle_pct = 0;

  task automatic emit_point(input logic [CpW-1:0] cp, input logic raw);
    result_t r;
    r.code_point   = cp;
    r.raw_fallback = raw;
    r.last_in_run  = 1'b0;
    r.text_done    = 1'b0;
    step_points.push_back(r);
  endtask

  task automatic flush_held();
    for (int i = 0; i < int'(held_cnt); i++) begin
      emit_point(CpW'(held_bytes[i]), 1'b1);
    end
    held_cnt = 2'd0;
    want_len = LenNone;
  endtask

  task automatic begin_char(input logic [7:0] b, input logic eot);
    logic [2:0] len;
    casez (b)
      8'b110?_????: len = LenTwo;
      8'b1110_????: len = LenThree;
      8'b1111_0???: len = LenFour;
      default:      len = LenNone;
    endcase
    if (!b[7]) begin
      emit_point(CpW'(b), 1'b0);
    end else if (len == LenNone || eot) begin
      emit_point(CpW'(b), 1'b1);
    end else begin
      held_bytes[0] = b;
      held_cnt      = 2'd1;
      want_len      = len;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [CpW-1:0] cp;
    step_points.delete();
    if (held_cnt == 2'd0) begin
      begin_char(b, eot);
    end else if (b[7:6] == 2'b10) begin
      if (int'(held_cnt) + 1 == int'(want_len)) begin
        case (want_len)
          LenTwo:   cp = CpW'(held_bytes[0][4:0]);
          LenThree: cp = CpW'(held_bytes[0][3:0]);
          default:  cp = CpW'(held_bytes[0][2:0]);
        endcase
        for (int i = 1; i < int'(held_cnt); i++) begin
          cp = (cp << 6) | CpW'(held_bytes[i][5:0]);
        end
        cp = (cp << 6) | CpW'(b[5:0]);
        emit_point(cp, 1'b0);
        held_cnt = 2'd0;
        want_len = LenNone;
      end else if (eot) begin
        // text ends inside the sequence
        flush_held();
        emit_point(CpW'(b), 1'b1);
      end else begin
        held_bytes[held_cnt] = b;
        held_cnt = held_cnt + 2'd1;
      end
    end else begin
      // breaking byte: emit what is held as raw bytes, then start over on this byte
      flush_held();
      begin_char(b, eot);
    end
    if (step_points.size() > 0) begin
      step_points[step_points.size()-1].last_in_run = 1'b1;
      step_points[step_points.size()-1].text_done   = eot;
    end
  endtask

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic eot, input bit typed,
                            input result_t fixed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    decode_byte(b, eot);
    if (typed) begin
      awaited.push_back(fixed);
    end else begin
      foreach (step_points[i]) awaited.push_back(step_points[i]);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------
  result_t got;
  result_t want;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= take_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      got.code_point   = m_tdata[CpW-1:0];
      got.raw_fallback = m_tuser[0];
      got.last_in_run  = m_tuser[1];
      got.text_done    = m_tlast;
      if (awaited.size() == 0) begin
        $error("unexpected code point %06h raw %0b", got.code_point, got.raw_fallback);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (got.code_point !== want.code_point) begin
          $error("code_point: expected %06h, got %06h", want.code_point, got.code_point);
          errors++;
        end
        if (got.raw_fallback !== want.raw_fallback) begin
          $error("raw_fallback: expected %0b, got %0b", want.raw_fallback,
                 got.raw_fallback);
          errors++;
        end
        if (got.last_in_run !== want.last_in_run) begin
          $error("last_in_run: expected %0b, got %0b", want.last_in_run,
                 got.last_in_run);
          errors++;
        end
        if (got.text_done !== want.text_done) begin
          $error("text_done: expected %0b, got %0b", want.text_done, got.text_done);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] b;
    logic       eot;
    bit         typed;
    result_t    fixed;
  } row_t;

  row_t script [ScriptLen] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h00, 1'b0, 1'b1, 1'b0}},   // lowest ascii
    '{8'h7F, 1'b1, 1'b1, '{21'h7F, 1'b0, 1'b1, 1'b1}},   // highest ascii, end of text
    '{8'h80, 1'b0, 1'b1, '{21'h80, 1'b1, 1'b1, 1'b0}},   // stray continuation
    '{8'hFF, 1'b0, 1'b1, '{21'hFF, 1'b1, 1'b1, 1'b0}},   // never a lead
    '{8'hF8, 1'b1, 1'b1, '{21'hF8, 1'b1, 1'b1, 1'b1}},
    '{8'hC3, 1'b1, 1'b1, '{21'hC3, 1'b1, 1'b1, 1'b1}},   // lead on the last byte
    '{8'hC2, 1'b0, 1'b0, '0},
    '{8'hA9, 1'b0, 1'b0, '0},
    '{8'hC0, 1'b0, 1'b0, '0},                            // overlong, decoded anyway
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hE2, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'hAC, 1'b1, 1'b0, '0},
    '{8'hF7, 1'b0, 1'b0, '0},                            // largest four-byte value
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b0, '0},                            // broken by ascii
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},                            // text ends mid sequence
    '{8'h90, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'hF1, 1'b0, 1'b0, '0},                            // broken by a lead on last byte
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hC5, 1'b1, 1'b0, '0}
  };

  initial begin
    int         pick;
    int         len;
    int         cut;
    logic [7:0] lead;
    logic [7:0] b;
    logic       end_flag;
    int         target;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          take_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          take_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (script[i]) offer_byte(script[i].b, script[i].eot, script[i].typed,
                                       script[i].fixed);
      end
      target = ScriptLen + 148 * (phase + 1);
      while (sent_items < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          // noise
          offer_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0, '0);
        end else begin
          len = (pick < 35) ? 1 : (pick < 57) ? 2 : (pick < 75) ? 3 : 4;
          case (len)
            1:       lead = 8'($urandom_range(8'h00, 8'h7F));
            2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
          endcase
          cut = len;
          if (len > 1 && $urandom_range(0, 99) < 15) cut = $urandom_range(1, len - 1);
          end_flag = ($urandom_range(0, 99) < 8);
          for (int j = 0; j < cut; j++) begin
            b = (j == 0) ? lead : {2'b10, 6'($urandom)};
            offer_byte(b, (j == cut - 1) ? end_flag : 1'b0, 1'b0, '0);
          end
        end
      end
      // hold off until the decoder has handed over everything
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (awaited.size() != 0) begin
      $error("%0d code points never arrived", awaited.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/uld_pkg.sv
hdl/uld_decode.sv
hdl/uld_outq.sv
hdl/utf8_lenient_decoder.sv
sim/tb_utf8_lenient_decoder.sv
